### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the dns reply parser modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define DRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define DRE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dre_pkg.sv
// ----------------------------------------------------------------------------
// dre_pkg
// shared types and constants of the dns reply a-record extractor
// ----------------------------------------------------------------------------
package dre_pkg;

	localparam logic [2:0] PH_HEADER      = 3'd0;
	localparam logic [2:0] PH_QNAME       = 3'd1;
	localparam logic [2:0] PH_ANAME_FIRST = 3'd2;
	localparam logic [2:0] PH_ANAME_LABEL = 3'd3;
	localparam logic [2:0] PH_AFIXED      = 3'd4;
	localparam logic [2:0] PH_RDATA       = 3'd5;
	localparam logic [2:0] PH_DONE        = 3'd6;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_ID    = 3'd2;
	localparam logic [2:0] ST_NO_ANSWER = 3'd3;
	localparam logic [2:0] ST_NO_RECORD = 3'd4;

	localparam logic [7:0]  PTR_MASK     = 8'hC0;
	localparam logic [3:0]  HDR_ID_HI    = 4'd0;
	localparam logic [3:0]  HDR_ID_LO    = 4'd1;
	localparam logic [3:0]  HDR_AN_HI    = 4'd6;
	localparam logic [3:0]  HDR_AN_LO    = 4'd7;
	localparam logic [3:0]  HDR_LAST     = 4'd11;
	localparam logic [3:0]  FX_TYPE_HI   = 4'd0;
	localparam logic [3:0]  FX_TYPE_LO   = 4'd1;
	localparam logic [3:0]  FX_RDLEN_HI  = 4'd8;
	localparam logic [3:0]  FX_RDLEN_LO  = 4'd9;
	localparam logic [3:0]  ADDR_BYTES   = 4'd4;
	localparam logic [15:0] QTAIL_LEN    = 16'd4;
	localparam logic [15:0] TYPE_A       = 16'd1;
	localparam logic [15:0] A_RDLEN      = 16'd4;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] address;
	} result_t;

endpackage

### rtl/core/dre_parser.sv
// ----------------------------------------------------------------------------
// dre_parser
// per-byte parse state and step logic, emits a result on the final byte
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dre_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        in_byte,
	input  logic              last_byte,
	input  logic [15:0]       pending_id,
	output logic              res_valid,
	output dre_pkg::result_t  res
);

	logic [2:0]  phase_q, phase_nx;
	logic [3:0]  header_index_q, header_index_nx;
	logic [15:0] id_seen_q, id_seen_nx;
	logic [15:0] answers_left_q, answers_left_nx;
	logic [15:0] skip_left_q, skip_left_nx;
	logic [3:0]  fixed_index_q, fixed_index_nx;
	logic [15:0] record_type_q, record_type_nx;
	logic [15:0] rdata_length_q, rdata_length_nx;
	logic [31:0] address_acc_q, address_acc_nx;
	logic        found_q, found_nx;
	logic [2:0]  verdict_q, verdict_nx;
	logic [15:0] rdlen_cur;
	logic [15:0] type_cur;
	logic [15:0] ans_dec;

	always_comb begin
		phase_nx        = phase_q;
		header_index_nx = header_index_q;
		id_seen_nx      = id_seen_q;
		answers_left_nx = answers_left_q;
		skip_left_nx    = skip_left_q;
		fixed_index_nx  = fixed_index_q;
		record_type_nx  = record_type_q;
		rdata_length_nx = rdata_length_q;
		address_acc_nx  = address_acc_q;
		found_nx        = found_q;
		verdict_nx      = verdict_q;
		res_valid       = 1'b0;
		res.status      = dre_pkg::ST_NO_RECORD;
		res.address     = 32'd0;
		type_cur        = record_type_q;
		rdlen_cur       = rdata_length_q;
		ans_dec         = answers_left_q - 16'd1;

		if (fixed_index_q == dre_pkg::FX_TYPE_HI) begin
			type_cur = {in_byte, record_type_q[7:0]};
		end else if (fixed_index_q == dre_pkg::FX_TYPE_LO) begin
			type_cur = {record_type_q[15:8], in_byte};
		end else if (fixed_index_q == dre_pkg::FX_RDLEN_HI) begin
			rdlen_cur = {in_byte, rdata_length_q[7:0]};
		end else if (fixed_index_q == dre_pkg::FX_RDLEN_LO) begin
			rdlen_cur = {rdata_length_q[15:8], in_byte};
		end

		if (step_en && phase_q != dre_pkg::PH_DONE) begin
			if (phase_q != dre_pkg::PH_HEADER && skip_left_q != 16'd0) begin
				skip_left_nx = skip_left_q - 16'd1;
			end else begin
				unique case (phase_q)
					dre_pkg::PH_HEADER: begin
						if (header_index_q == dre_pkg::HDR_ID_HI) begin
							id_seen_nx = {in_byte, id_seen_q[7:0]};
						end else if (header_index_q == dre_pkg::HDR_ID_LO) begin
							id_seen_nx = {id_seen_q[15:8], in_byte};
						end else if (header_index_q == dre_pkg::HDR_AN_HI) begin
							answers_left_nx = {in_byte, answers_left_q[7:0]};
						end else if (header_index_q == dre_pkg::HDR_AN_LO) begin
							answers_left_nx = {answers_left_q[15:8], in_byte};
						end
						if (header_index_q >= dre_pkg::HDR_LAST) begin
							if (id_seen_q != pending_id) begin
								phase_nx   = dre_pkg::PH_DONE;
								verdict_nx = dre_pkg::ST_BAD_ID;
							end else if (answers_left_q == 16'd0) begin
								phase_nx   = dre_pkg::PH_DONE;
								verdict_nx = dre_pkg::ST_NO_ANSWER;
							end else begin
								phase_nx = dre_pkg::PH_QNAME;
							end
						end else begin
							header_index_nx = header_index_q + 4'd1;
						end
					end
					dre_pkg::PH_QNAME: begin
						if (in_byte == 8'd0) begin
							skip_left_nx = dre_pkg::QTAIL_LEN;
							phase_nx     = dre_pkg::PH_ANAME_FIRST;
						end else begin
							skip_left_nx = {8'd0, in_byte};
						end
					end
					dre_pkg::PH_ANAME_FIRST: begin
						if ((in_byte & dre_pkg::PTR_MASK) == dre_pkg::PTR_MASK) begin
							skip_left_nx   = 16'd1;
							fixed_index_nx = 4'd0;
							phase_nx       = dre_pkg::PH_AFIXED;
						end else if (in_byte == 8'd0) begin
							fixed_index_nx = 4'd0;
							phase_nx       = dre_pkg::PH_AFIXED;
						end else begin
							skip_left_nx = {8'd0, in_byte};
							phase_nx     = dre_pkg::PH_ANAME_LABEL;
						end
					end
					dre_pkg::PH_ANAME_LABEL: begin
						if (in_byte == 8'd0) begin
							fixed_index_nx = 4'd0;
							phase_nx       = dre_pkg::PH_AFIXED;
						end else begin
							skip_left_nx = {8'd0, in_byte};
						end
					end
					dre_pkg::PH_AFIXED: begin
						record_type_nx  = type_cur;
						rdata_length_nx = rdlen_cur;
						if (fixed_index_q >= dre_pkg::FX_RDLEN_LO) begin
							fixed_index_nx = 4'd0;
							if (type_cur == dre_pkg::TYPE_A && rdlen_cur == dre_pkg::A_RDLEN) begin
								address_acc_nx = 32'd0;
								phase_nx       = dre_pkg::PH_RDATA;
							end else begin
								skip_left_nx    = rdlen_cur;
								answers_left_nx = ans_dec;
								if (ans_dec == 16'd0) begin
									phase_nx   = dre_pkg::PH_DONE;
									verdict_nx = dre_pkg::ST_NO_RECORD;
								end else begin
									phase_nx = dre_pkg::PH_ANAME_FIRST;
								end
							end
						end else begin
							fixed_index_nx = fixed_index_q + 4'd1;
						end
					end
					dre_pkg::PH_RDATA: begin
						address_acc_nx = {address_acc_q[23:0], in_byte};
						fixed_index_nx = fixed_index_q + 4'd1;
						if (fixed_index_nx >= dre_pkg::ADDR_BYTES) begin
							found_nx   = 1'b1;
							phase_nx   = dre_pkg::PH_DONE;
							verdict_nx = dre_pkg::ST_FOUND;
						end
					end
					default: begin
						phase_nx   = dre_pkg::PH_DONE;
						verdict_nx = dre_pkg::ST_NO_RECORD;
					end
				endcase
			end
		end

		if (step_en && last_byte) begin
			res_valid = 1'b1;
			priority if (phase_nx == dre_pkg::PH_HEADER) begin
				res.status = dre_pkg::ST_SHORT;
			end else if (found_nx) begin
				res.status = dre_pkg::ST_FOUND;
			end else if (phase_nx == dre_pkg::PH_DONE) begin
				res.status = verdict_nx;
			end else begin
				res.status = dre_pkg::ST_NO_RECORD;
			end
			res.address = (res.status == dre_pkg::ST_FOUND) ? address_acc_nx : 32'd0;

			phase_nx        = dre_pkg::PH_HEADER;
			header_index_nx = 4'd0;
			id_seen_nx      = 16'd0;
			answers_left_nx = 16'd0;
			skip_left_nx    = 16'd0;
			fixed_index_nx  = 4'd0;
			record_type_nx  = 16'd0;
			rdata_length_nx = 16'd0;
			address_acc_nx  = 32'd0;
			found_nx        = 1'b0;
			verdict_nx      = dre_pkg::ST_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= dre_pkg::PH_HEADER;
			header_index_q <= 4'd0;
			id_seen_q      <= 16'd0;
			answers_left_q <= 16'd0;
			skip_left_q    <= 16'd0;
			fixed_index_q  <= 4'd0;
			record_type_q  <= 16'd0;
			rdata_length_q <= 16'd0;
			address_acc_q  <= 32'd0;
			found_q        <= 1'b0;
			verdict_q      <= dre_pkg::ST_FOUND;
		end else begin
			phase_q        <= phase_nx;
			header_index_q <= header_index_nx;
			id_seen_q      <= id_seen_nx;
			answers_left_q <= answers_left_nx;
			skip_left_q    <= skip_left_nx;
			fixed_index_q  <= fixed_index_nx;
			record_type_q  <= record_type_nx;
			rdata_length_q <= rdata_length_nx;
			address_acc_q  <= address_acc_nx;
			found_q        <= found_nx;
			verdict_q      <= verdict_nx;
		end
	end

	`DRE_ASSERT(a_found_done, found_q |-> (phase_q == dre_pkg::PH_DONE && verdict_q == dre_pkg::ST_FOUND), "found without done verdict")
	`DRE_ASSERT(a_last_clears, (step_en && last_byte) |=> (phase_q == dre_pkg::PH_HEADER && header_index_q == 4'd0), "state not cleared after final byte")
	`DRE_ASSERT(a_header_clean, (phase_q == dre_pkg::PH_HEADER) |-> (skip_left_q == 16'd0 && !found_q), "skip or found set in header")
	`DRE_ASSERT(a_rdata_index, (phase_q == dre_pkg::PH_RDATA) |-> (fixed_index_q < dre_pkg::ADDR_BYTES), "rdata index past address")

endmodule

### rtl/core/dre_out_reg.sv
// ----------------------------------------------------------------------------
// dre_out_reg
// result register holding one result item until the receiver takes it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dre_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dre_pkg::result_t  res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [31:0]       address
);

	logic              valid_q;
	dre_pkg::result_t  res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign status    = res_q.status;
	assign address   = res_q.address;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	`DRE_ASSERT(a_no_overwrite, (valid_q && !out_ready) |-> !load, "result loaded into full register")
	`DRE_ASSERT(a_addr_zero, (valid_q && res_q.status != dre_pkg::ST_FOUND) |-> (res_q.address == 32'd0), "address set without found status")
	`DRE_ASSERT(a_status_range, valid_q |-> (res_q.status <= dre_pkg::ST_NO_RECORD), "status code out of range")

endmodule

### rtl/core/dns_reply_a_record_extractor_top.sv
// ----------------------------------------------------------------------------
// dns_reply_a_record_extractor_top
// dns response parser returning the first a-record ipv4 address
// ----------------------------------------------------------------------------
// usage
//   in channel: one payload byte per item (in_byte), last_byte marks the end
//   of a reply. out channel: one item (status, address) per reply, issued for
//   the final byte only. cfg_wr_en/cfg_wr_data load the pending transaction
//   id; write it only while no reply is in flight.
//   flow: a byte is taken into an input register, parsed from there by the
//   parser state machine, and the result of the final byte is loaded into
//   the output register, which drives out_valid. one byte is taken every
//   cycle unless a final byte is held in the input register (see stall).
//   reset: parser returns to the header phase, pending id clears to zero,
//   no result is pending.
//   stall: while a result waits, non-final bytes keep flowing; a final byte
//   waits in the input register until the output register frees, and
//   in_ready drops only then.
// ----------------------------------------------------------------------------
module dns_reply_a_record_extractor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] address,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              fire_s1;
	logic              out_free;
	logic              res_valid;
	dre_pkg::result_t  res;
	logic [15:0]       pending_id_q;

	assign fire_s1  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_id_q <= 16'd0;
		end else if (cfg_wr_en) begin
			pending_id_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
	end

	dre_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (fire_s1),
		.in_byte    (byte_s1),
		.last_byte  (last_s1),
		.pending_id (pending_id_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	dre_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.address   (address)
	);

endmodule

### test/dns_reply_checker.sv
// ----------------------------------------------------------------------------
// dns_reply_checker
// Watches both channels and the config port of the dns reply extractor. Each
// accepted byte is run through a byte-level parser model. Each final byte
// queues the expected status and address. Each accepted result is compared
// field by field against the oldest queued reply.
// ----------------------------------------------------------------------------
module dns_reply_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [31:0] address,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output int          results_due,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] want_id;
	logic [2:0]  ph;
	logic [3:0]  hdr_pos;
	logic [15:0] id_acc;
	logic [15:0] an_left;
	logic [15:0] skip_cnt;
	logic [3:0]  fx_pos;
	logic [15:0] rtype;
	logic [15:0] rdlen;
	logic [31:0] addr_acc;
	logic        hit;
	logic [2:0]  decided;

	dre_pkg::result_t expected_replies[$];
	dre_pkg::result_t want;
	int               errors = 0;

	task automatic clear_parse();
		ph = dre_pkg::PH_HEADER;
		hdr_pos = '0;
		id_acc = '0;
		an_left = '0;
		skip_cnt = '0;
		fx_pos = '0;
		rtype = '0;
		rdlen = '0;
		addr_acc = '0;
		hit = 1'b0;
		decided = dre_pkg::ST_FOUND;
	endtask

	task automatic settle(input logic [2:0] code);
		ph = dre_pkg::PH_DONE;
		decided = code;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		if (ph == dre_pkg::PH_DONE)
			return;
		if (ph != dre_pkg::PH_HEADER && skip_cnt != 0) begin
			skip_cnt--;
			return;
		end
		case (ph)
			dre_pkg::PH_HEADER: begin
				case (hdr_pos)
					dre_pkg::HDR_ID_HI: id_acc[15:8] = b;
					dre_pkg::HDR_ID_LO: id_acc[7:0] = b;
					dre_pkg::HDR_AN_HI: an_left[15:8] = b;
					dre_pkg::HDR_AN_LO: an_left[7:0] = b;
					default: ;
				endcase
				if (hdr_pos >= dre_pkg::HDR_LAST) begin
					if (id_acc != want_id)
						settle(dre_pkg::ST_BAD_ID);
					else if (an_left == 0)
						settle(dre_pkg::ST_NO_ANSWER);
					else
						ph = dre_pkg::PH_QNAME;
				end else
					hdr_pos++;
			end
			dre_pkg::PH_QNAME: begin
				if (b == 0) begin
					skip_cnt = dre_pkg::QTAIL_LEN;
					ph = dre_pkg::PH_ANAME_FIRST;
				end else
					skip_cnt = {8'h00, b};
			end
			dre_pkg::PH_ANAME_FIRST: begin
				if ((b & dre_pkg::PTR_MASK) == dre_pkg::PTR_MASK) begin
					skip_cnt = 16'd1;
					fx_pos = '0;
					ph = dre_pkg::PH_AFIXED;
				end else if (b == 0) begin
					fx_pos = '0;
					ph = dre_pkg::PH_AFIXED;
				end else begin
					skip_cnt = {8'h00, b};
					ph = dre_pkg::PH_ANAME_LABEL;
				end
			end
			dre_pkg::PH_ANAME_LABEL: begin
				if (b == 0) begin
					fx_pos = '0;
					ph = dre_pkg::PH_AFIXED;
				end else
					skip_cnt = {8'h00, b};
			end
			dre_pkg::PH_AFIXED: begin
				case (fx_pos)
					dre_pkg::FX_TYPE_HI: rtype[15:8] = b;
					dre_pkg::FX_TYPE_LO: rtype[7:0] = b;
					dre_pkg::FX_RDLEN_HI: rdlen[15:8] = b;
					dre_pkg::FX_RDLEN_LO: rdlen[7:0] = b;
					default: ;
				endcase
				if (fx_pos >= dre_pkg::FX_RDLEN_LO) begin
					fx_pos = '0;
					if (rtype == dre_pkg::TYPE_A && rdlen == dre_pkg::A_RDLEN) begin
						addr_acc = '0;
						ph = dre_pkg::PH_RDATA;
					end else begin
						skip_cnt = rdlen;
						an_left--;
						if (an_left == 0)
							settle(dre_pkg::ST_NO_RECORD);
						else
							ph = dre_pkg::PH_ANAME_FIRST;
					end
				end else
					fx_pos++;
			end
			dre_pkg::PH_RDATA: begin
				addr_acc = {addr_acc[23:0], b};
				fx_pos++;
				if (fx_pos >= dre_pkg::ADDR_BYTES) begin
					hit = 1'b1;
					settle(dre_pkg::ST_FOUND);
				end
			end
			default: settle(dre_pkg::ST_NO_RECORD);
		endcase
	endtask

	task automatic close_reply();
		dre_pkg::result_t r;
		if (ph == dre_pkg::PH_HEADER)
			r.status = dre_pkg::ST_SHORT;
		else if (hit)
			r.status = dre_pkg::ST_FOUND;
		else if (ph == dre_pkg::PH_DONE)
			r.status = decided;
		else
			r.status = dre_pkg::ST_NO_RECORD;
		r.address = (r.status == dre_pkg::ST_FOUND) ? addr_acc : '0;
		expected_replies.push_back(r);
		clear_parse();
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		$display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, exp_val);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_id = '0;
			clear_parse();
			expected_replies.delete();
			results_due <= 0;
		end else begin
			if (cfg_wr_en)
				want_id = cfg_wr_data;
			if (in_valid && in_ready) begin
				parse_byte(in_byte);
				if (last_byte)
					close_reply();
			end
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0)
					report("unexpected result, status", {29'd0, status}, 32'd0);
				else begin
					want = expected_replies.pop_front();
					if (status !== want.status)
						report("status", {29'd0, status}, {29'd0, want.status});
					if (address !== want.address)
						report("address", address, want.address);
				end
			end
			results_due <= expected_replies.size();
		end
		mismatches <= errors;
	end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds dns response payloads byte by byte into the a-record extractor. A
// short directed set comes first: short replies, id mismatch, zero answers,
// pointer, root and label names, truncation and the address extremes. Random
// well-formed, broken and noise replies follow under several pending ids.
// Both sides idle at random, and one phase holds the output off for a long
// stretch. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAME_PTR    = 0;
	localparam int NAME_ROOT   = 1;
	localparam int NAME_LABELS = 2;

	localparam logic [15:0] TYPE_CNAME   = 16'h0005;
	localparam logic [15:0] TYPE_SWAPPED = 16'h0100;

	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] address;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	logic        calm = 1'b0;
	logic        hold_request = 1'b0;
	int          results_due;
	int          mismatches;
	int          quiet_cycles = 0;
	int          bytes_sent = 0;
	logic [15:0] pid = '0;
	logic [7:0]  frame[$];

	dns_reply_a_record_extractor_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.address     (address),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	dns_reply_checker reply_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.address     (address),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.results_due (results_due),
		.mismatches  (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 17);
		end
	end

	function automatic logic [7:0] pick_seg_len(input logic [7:0] hi);
		if ($urandom_range(99) < 6)
			return 8'($urandom_range(1, hi));
		return 8'($urandom_range(1, 6));
	endfunction

	task automatic put_rand(input int n);
		repeat (n) frame.push_back(8'($urandom_range(255)));
	endtask

	task automatic put_word(input logic [31:0] w);
		frame.push_back(w[31:24]);
		frame.push_back(w[23:16]);
		frame.push_back(w[15:8]);
		frame.push_back(w[7:0]);
	endtask

	task automatic put_header(input logic [15:0] id, input logic [15:0] ancount);
		frame.push_back(id[15:8]);
		frame.push_back(id[7:0]);
		put_rand(4);
		frame.push_back(ancount[15:8]);
		frame.push_back(ancount[7:0]);
		put_rand(4);
	endtask

	task automatic put_qname();
		int labels;
		logic [7:0] len;
		labels = $urandom_range(0, 3);
		repeat (labels) begin
			len = pick_seg_len(8'hFF);
			frame.push_back(len);
			put_rand(int'(len));
		end
		frame.push_back(8'h00);
		put_rand(int'(dre_pkg::QTAIL_LEN));
	endtask

	task automatic put_aname(input int kind);
		logic [7:0] v;
		int labels;
		case (kind)
			NAME_PTR: begin
				v = 8'($urandom_range(63));
				frame.push_back(dre_pkg::PTR_MASK | v);
				put_rand(1);
			end
			NAME_ROOT: frame.push_back(8'h00);
			default: begin
				v = pick_seg_len(8'hBF);
				frame.push_back(v);
				put_rand(int'(v));
				labels = $urandom_range(0, 2);
				repeat (labels) begin
					v = pick_seg_len(8'hFF);
					frame.push_back(v);
					put_rand(int'(v));
				end
				frame.push_back(8'h00);
			end
		endcase
	endtask

	// type, class, ttl, rdata length
	task automatic put_fixed(input logic [15:0] rtype, input logic [15:0] rdlen);
		frame.push_back(rtype[15:8]);
		frame.push_back(rtype[7:0]);
		put_rand(6);
		frame.push_back(rdlen[15:8]);
		frame.push_back(rdlen[7:0]);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++) begin
			while (!calm && $urandom_range(99) < 17) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= frame[i];
			last_byte <= (i == frame.size() - 1);
			do @(posedge clk); while (!in_ready);
			bytes_sent++;
		end
	endtask

	task automatic load_pending_id(input logic [15:0] v);
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pid = v;
	endtask

	task automatic build_random_frame();
		int k;
		int n;
		int nrec;
		logic [15:0] id;
		logic [15:0] flip;
		logic [15:0] ancount;
		logic [15:0] rtype;
		logic [15:0] rdlen;
		frame.delete();
		k = $urandom_range(99);
		if (k < 8) begin
			put_rand($urandom_range(1, 30));
			return;
		end
		if (k < 14) begin
			put_rand($urandom_range(1, 11));
			return;
		end
		id = pid;
		if (k < 22) begin
			flip = 16'h0001 << $urandom_range(15);
			id = pid ^ flip;
		end else if (k < 26) begin
			flip = 16'($urandom_range(1, 65535));
			id = pid ^ flip;
		end
		k = $urandom_range(99);
		if (k < 6)
			ancount = '0;
		else if (k < 10)
			ancount = 16'hFFFF;
		else if (k < 14)
			ancount = 16'($urandom_range(65535));
		else
			ancount = 16'($urandom_range(1, 4));
		put_header(id, ancount);
		put_qname();
		nrec = $urandom_range(0, 4);
		repeat (nrec) begin
			put_aname($urandom_range(NAME_PTR, NAME_LABELS));
			k = $urandom_range(99);
			n = -1;
			if (k < 40) begin
				rtype = dre_pkg::TYPE_A;
				rdlen = dre_pkg::A_RDLEN;
			end else if (k < 55) begin
				rtype = dre_pkg::TYPE_A;
				rdlen = 16'($urandom_range(0, 8));
			end else if (k < 70) begin
				rtype = (k < 62) ? TYPE_SWAPPED : TYPE_CNAME;
				rdlen = dre_pkg::A_RDLEN;
			end else if (k < 92) begin
				rtype = 16'($urandom_range(65535));
				rdlen = 16'($urandom_range(0, 12));
			end else begin
				rtype = 16'($urandom_range(65535));
				rdlen = 16'($urandom_range(65535));
				n = $urandom_range(0, 12);
			end
			put_fixed(rtype, rdlen);
			if (n < 0)
				n = int'(rdlen);
			put_rand(n);
		end
		put_rand($urandom_range(0, 4));
		if ($urandom_range(99) < 20) begin
			n = $urandom_range(1, frame.size());
			while (frame.size() > n)
				frame.pop_back();
		end
	endtask

	task automatic run_directed();
		// lone byte, then a header cut one byte short
		frame.delete();
		frame.push_back(8'hFF);
		send_frame();
		frame.delete();
		put_rand(11);
		send_frame();
		// id mismatch together with zero answers
		frame.delete();
		put_header(~pid, 16'h0000);
		send_frame();
		// zero answers, trailing bytes ignored
		frame.delete();
		put_header(pid, 16'h0000);
		put_rand(3);
		send_frame();
		// ends on the last header byte
		frame.delete();
		put_header(pid, 16'h0001);
		send_frame();
		// pointer name, all-ones address
		frame.delete();
		put_header(pid, 16'h0001);
		frame.push_back(8'h00);
		put_rand(4);
		put_aname(NAME_PTR);
		put_fixed(dre_pkg::TYPE_A, dre_pkg::A_RDLEN);
		put_word(32'hFFFF_FFFF);
		put_rand(2);
		send_frame();
		// label name whose second length has both top bits set, zero address
		frame.delete();
		put_header(pid, 16'h0002);
		frame.push_back(8'h03);
		put_rand(3);
		frame.push_back(8'h00);
		put_rand(4);
		frame.push_back(8'h02);
		put_rand(2);
		frame.push_back(8'hC3);
		put_rand(8'hC3);
		frame.push_back(8'h00);
		put_fixed(dre_pkg::TYPE_A, dre_pkg::A_RDLEN);
		put_word(32'h0000_0000);
		send_frame();
		// root name with cname first, a record second
		frame.delete();
		put_header(pid, 16'h0003);
		put_qname();
		put_aname(NAME_ROOT);
		put_fixed(TYPE_CNAME, 16'h0003);
		put_rand(3);
		put_aname(NAME_PTR);
		put_fixed(dre_pkg::TYPE_A, dre_pkg::A_RDLEN);
		put_word(32'h0102_0304);
		send_frame();
		// a record with wrong length, answers used up
		frame.delete();
		put_header(pid, 16'h0001);
		put_qname();
		put_aname(NAME_PTR);
		put_fixed(dre_pkg::TYPE_A, 16'h0005);
		put_rand(5);
		put_rand(6);
		send_frame();
		// rdata cut after two bytes
		frame.delete();
		put_header(pid, 16'h0001);
		put_qname();
		put_aname(NAME_PTR);
		put_fixed(dre_pkg::TYPE_A, dre_pkg::A_RDLEN);
		put_rand(2);
		send_frame();
		// byte-swapped type, then long rdata length
		frame.delete();
		put_header(pid, 16'h0002);
		put_qname();
		put_aname(NAME_PTR);
		put_fixed(TYPE_SWAPPED, dre_pkg::A_RDLEN);
		put_rand(4);
		put_aname(NAME_ROOT);
		put_fixed(dre_pkg::TYPE_A, 16'h0104);
		put_rand(2);
		send_frame();
		// max answer count, longest question label
		frame.delete();
		put_header(pid, 16'hFFFF);
		frame.push_back(8'hFF);
		put_rand(255);
		frame.push_back(8'h00);
		put_rand(4);
		put_aname(NAME_PTR);
		put_fixed(dre_pkg::TYPE_A, dre_pkg::A_RDLEN);
		put_word(32'h8000_0001);
		send_frame();
		// ends inside the question
		frame.delete();
		put_header(pid, 16'h0001);
		frame.push_back(8'h05);
		put_rand(2);
		send_frame();
		// ends inside the fixed answer fields
		frame.delete();
		put_header(pid, 16'h0001);
		put_qname();
		put_aname(NAME_PTR);
		put_rand(5);
		send_frame();
	endtask

	initial begin : stimulus
		logic [15:0] id_plan [6];
		int phase_start;
		int frames;
		id_plan[0] = 16'hFFFF;
		id_plan[1] = 16'h0001;
		id_plan[2] = 16'h8000;
		id_plan[3] = 16'($urandom_range(65535));
		id_plan[4] = 16'($urandom_range(65535));
		id_plan[5] = 16'h0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 6; p++) begin
			load_pending_id(id_plan[p]);
			calm <= (p == 1);
			if (p == 3) begin
				hold_request <= 1'b1;
				@(posedge clk);
				hold_request <= 1'b0;
			end
			phase_start = bytes_sent;
			frames = 0;
			while (bytes_sent - phase_start < 100 || frames < 2) begin
				build_random_frame();
				send_frame();
				frames++;
			end
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dre_pkg.sv
rtl/core/dre_parser.sv
rtl/core/dre_out_reg.sv
rtl/core/dns_reply_a_record_extractor_top.sv
test/dns_reply_checker.sv
test/testbench.sv
